FILE: src/tls_pkg.sv
// ----------------------------------------------------------------------------
// tls_pkg
// shared widths, pair tables and beat types of the triangle stiffness unit;
// coordinates are signed Q16.16 and entries signed Q32.16, the binary point cancels out
// ----------------------------------------------------------------------------
package tls_pkg;

   localparam int CoordBits  = 32;
   localparam int CondBits   = 31;
   localparam int OutBits    = 48;
   localparam int Lanes      = 6;
   localparam int DiffBits   = CoordBits + 1;
   localparam int ProdBits   = 2 * DiffBits;
   localparam int SumBits    = ProdBits + 1;
   localparam int AbsBits    = ProdBits;
   localparam int SplitBits  = (AbsBits + 1) / 2;
   localparam int PartBits   = CondBits + SplitBits;
   localparam int NumBits    = CondBits + AbsBits;
   localparam int DenBits    = AbsBits + 1;
   localparam int QuotBits   = OutBits + 1;
   localparam int HiBits     = NumBits - QuotBits;
   localparam int GradStages = 3;
   localparam int ScaleStages = 3;
   localparam int Latency    = GradStages + ScaleStages + QuotBits + 2;

   localparam int PairRow [Lanes] = '{0, 0, 0, 1, 1, 2};
   localparam int PairCol [Lanes] = '{0, 1, 2, 1, 2, 2};

   typedef struct packed {
      logic signed [CoordBits-1:0] ax;
      logic signed [CoordBits-1:0] ay;
      logic signed [CoordBits-1:0] bx;
      logic signed [CoordBits-1:0] by_coord;
      logic signed [CoordBits-1:0] cx;
      logic signed [CoordBits-1:0] cy;
      logic [CondBits-1:0]         conductivity;
   } req_type;

   typedef struct packed {
      logic signed [OutBits-1:0] k_aa;
      logic signed [OutBits-1:0] k_ab;
      logic signed [OutBits-1:0] k_ac;
      logic signed [OutBits-1:0] k_bb;
      logic signed [OutBits-1:0] k_bc;
      logic signed [OutBits-1:0] k_cc;
      logic                      degenerate;
      logic                      saturated;
   } rsp_type;

   typedef struct packed {
      logic signed [SumBits-1:0]      det;
      logic [Lanes-1:0][SumBits-1:0]  sum;
      logic [CondBits-1:0]            cond;
   } grad_type;

   typedef struct packed {
      logic [Lanes-1:0][NumBits-1:0] num;
      logic [DenBits-1:0]            den;
      logic [Lanes-1:0]              neg;
      logic                          degen;
   } num_type;

   typedef struct packed {
      logic neg;
      logic degen;
   } div_tag_type;

endpackage

FILE: src/triangle_laplace_stiffness_unit.sv
// ----------------------------------------------------------------------------
// triangle_laplace_stiffness_unit
// element stiffness of a linear triangle: six entries c*(bi*bj+gi*gj)/(2|det|)
//
//   channel   ports                  direction   beat
//   request   start, busy, req_data  in          start && !busy
//   response  rsp_valid, rsp_data    out         rsp_valid, one cycle
//
// one beat per cycle, busy stays low; each response leaves once its request
// has passed the 6 front stages, the 50-stage divider lanes and the output
// register. synchronous reset drops every beat in flight. the receiver
// cannot stall, so no stage ever holds.
// ----------------------------------------------------------------------------
module triangle_laplace_stiffness_unit import tls_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   logic                grad_valid, num_valid;
   grad_type            grad_data;
   num_type             num_data;
   logic [Lanes-1:0]    lane_valid, lane_huge;
   logic [QuotBits-1:0] lane_quo [Lanes];
   div_tag_type         lane_tag [Lanes];
   logic [OutBits-1:0]  entry [Lanes];
   logic [QuotBits-1:0] mag;
   logic                lane_sat, any_sat;
   logic                rsp_valid_ff;
   rsp_type             rsp_ff, rsp_in;

   localparam logic [QuotBits-1:0] Lim = QuotBits'(1) << (OutBits - 1);

   assign busy = 1'b0;

   tls_grad u_grad (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start && !busy),
      .in_data   (req_data),
      .out_valid (grad_valid),
      .out_data  (grad_data)
   );

   tls_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (grad_valid),
      .in_data   (grad_data),
      .out_valid (num_valid),
      .out_data  (num_data)
   );

   for (genvar k = 0; k < Lanes; k++) begin : g_lane
      tls_div u_div (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (num_valid),
         .in_num    (num_data.num[k]),
         .in_den    (num_data.den),
         .in_tag    ('{neg: num_data.neg[k], degen: num_data.degen}),
         .out_valid (lane_valid[k]),
         .out_quo   (lane_quo[k]),
         .out_huge  (lane_huge[k]),
         .out_tag   (lane_tag[k])
      );
   end

   always_comb begin
      any_sat  = 1'b0;
      mag      = '0;
      lane_sat = 1'b0;
      for (int k = 0; k < Lanes; k++) begin
         if (lane_tag[k].neg) begin
            lane_sat = lane_huge[k] || (lane_quo[k] > Lim);
            mag      = lane_sat ? Lim : lane_quo[k];
            entry[k] = OutBits'(-mag);
         end else begin
            lane_sat = lane_huge[k] || (lane_quo[k] > Lim - 1'b1);
            mag      = lane_sat ? Lim - 1'b1 : lane_quo[k];
            entry[k] = OutBits'(mag);
         end
         any_sat = any_sat | lane_sat;
      end
      if (lane_tag[0].degen) begin
         rsp_in = '0;
         rsp_in.degenerate = 1'b1;
      end else begin
         rsp_in.k_aa       = entry[0];
         rsp_in.k_ab       = entry[1];
         rsp_in.k_ac       = entry[2];
         rsp_in.k_bb       = entry[3];
         rsp_in.k_bc       = entry[4];
         rsp_in.k_cc       = entry[5];
         rsp_in.degenerate = 1'b0;
         rsp_in.saturated  = any_sat;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= lane_valid[0];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_latency: assert property (@(posedge clock) disable iff (reset)
      start && !busy |-> ##Latency rsp_valid)
      else $error("request beat without response");

   a_no_orphan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, Latency))
      else $error("response beat without request");

   a_lanes_aligned: assert property (@(posedge clock) disable iff (reset)
      lane_valid[0] |-> (lane_valid == '1) && lane_tag[0].degen == lane_tag[5].degen)
      else $error("divider lanes out of step");

   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.degenerate |-> !rsp_data.saturated
         && rsp_data.k_aa == '0 && rsp_data.k_cc == '0)
      else $error("degenerate beat not cleared");

endmodule

FILE: src/tls_grad.sv
// ----------------------------------------------------------------------------
// tls_grad
// edge differences, products and sums: determinant and gradient dot products
// ----------------------------------------------------------------------------
module tls_grad import tls_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   input  req_type  in_data,
   output logic     out_valid,
   output grad_type out_data
);

   logic                       va_ff, vb_ff, vc_ff;
   logic signed [DiffBits-1:0] e1x_ff, e1y_ff, e2x_ff, e2y_ff;
   logic signed [DiffBits-1:0] b_ff [3];
   logic signed [DiffBits-1:0] g_ff [3];
   logic [CondBits-1:0]        cond_a_ff, cond_b_ff;
   logic signed [ProdBits-1:0] detp_ff, detq_ff, detp_in, detq_in;
   logic signed [ProdBits-1:0] bb_ff [Lanes];
   logic signed [ProdBits-1:0] gg_ff [Lanes];
   logic signed [ProdBits-1:0] bb_in [Lanes];
   logic signed [ProdBits-1:0] gg_in [Lanes];
   grad_type                   out_ff, out_in;
   logic signed [DiffBits-1:0] x0, y0, x1, y1, x2, y2;

   assign x0 = DiffBits'(in_data.ax);
   assign y0 = DiffBits'(in_data.ay);
   assign x1 = DiffBits'(in_data.bx);
   assign y1 = DiffBits'(in_data.by_coord);
   assign x2 = DiffBits'(in_data.cx);
   assign y2 = DiffBits'(in_data.cy);

   always_ff @(posedge clock) begin
      e1x_ff    <= x1 - x0;
      e1y_ff    <= y1 - y0;
      e2x_ff    <= x2 - x0;
      e2y_ff    <= y2 - y0;
      b_ff[0]   <= y1 - y2;
      b_ff[1]   <= y2 - y0;
      b_ff[2]   <= y0 - y1;
      g_ff[0]   <= x2 - x1;
      g_ff[1]   <= x0 - x2;
      g_ff[2]   <= x1 - x0;
      cond_a_ff <= in_data.conductivity;
   end

   always_comb begin
      detp_in = e1x_ff * e2y_ff;
      detq_in = e1y_ff * e2x_ff;
      for (int k = 0; k < Lanes; k++) begin
         bb_in[k] = b_ff[PairRow[k]] * b_ff[PairCol[k]];
         gg_in[k] = g_ff[PairRow[k]] * g_ff[PairCol[k]];
      end
   end

   always_ff @(posedge clock) begin
      detp_ff   <= detp_in;
      detq_ff   <= detq_in;
      bb_ff     <= bb_in;
      gg_ff     <= gg_in;
      cond_b_ff <= cond_a_ff;
   end

   always_comb begin
      out_in.det  = SumBits'(detp_ff) - SumBits'(detq_ff);
      out_in.cond = cond_b_ff;
      for (int k = 0; k < Lanes; k++) begin
         out_in.sum[k] = SumBits'(bb_ff[k]) + SumBits'(gg_ff[k]);
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
      end else begin
         va_ff <= in_valid;
         vb_ff <= va_ff;
         vc_ff <= vb_ff;
      end
   end

   assign out_valid = vc_ff;
   assign out_data  = out_ff;

endmodule

FILE: src/tls_scale.sv
// ----------------------------------------------------------------------------
// tls_scale
// magnitudes, conductivity scaling in split products and rounded numerator
// ----------------------------------------------------------------------------
module tls_scale import tls_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   input  grad_type in_data,
   output logic     out_valid,
   output num_type  out_data
);

   logic                  vd_ff, ve_ff, vf_ff;
   logic [AbsBits-1:0]    adet_d_ff, adet_e_ff, adet_in;
   logic [AbsBits-1:0]    mag_ff [Lanes];
   logic [AbsBits-1:0]    mag_in [Lanes];
   logic [Lanes-1:0]      neg_d_ff, neg_e_ff, neg_in;
   logic                  degen_d_ff, degen_e_ff;
   logic [CondBits-1:0]   cond_d_ff;
   logic [PartBits-1:0]   plo_ff [Lanes];
   logic [PartBits-1:0]   phi_ff [Lanes];
   logic [PartBits-1:0]   plo_in [Lanes];
   logic [PartBits-1:0]   phi_in [Lanes];
   num_type               out_ff, out_in;
   logic signed [SumBits-1:0] sv;

   always_comb begin
      adet_in = in_data.det[SumBits-1] ? AbsBits'(-in_data.det) : AbsBits'(in_data.det);
      sv = '0;
      for (int k = 0; k < Lanes; k++) begin
         sv        = $signed(in_data.sum[k]);
         neg_in[k] = sv[SumBits-1];
         mag_in[k] = sv[SumBits-1] ? AbsBits'(-sv) : AbsBits'(sv);
      end
   end

   always_ff @(posedge clock) begin
      adet_d_ff  <= adet_in;
      mag_ff     <= mag_in;
      neg_d_ff   <= neg_in;
      degen_d_ff <= (in_data.det == '0);
      cond_d_ff  <= in_data.cond;
   end

   always_comb begin
      for (int k = 0; k < Lanes; k++) begin
         plo_in[k] = PartBits'(cond_d_ff) * PartBits'(mag_ff[k][SplitBits-1:0]);
         phi_in[k] = PartBits'(cond_d_ff) * PartBits'(mag_ff[k][AbsBits-1:SplitBits]);
      end
   end

   always_ff @(posedge clock) begin
      plo_ff     <= plo_in;
      phi_ff     <= phi_in;
      adet_e_ff  <= adet_d_ff;
      neg_e_ff   <= neg_d_ff;
      degen_e_ff <= degen_d_ff;
   end

   always_comb begin
      out_in.den   = {adet_e_ff, 1'b0};
      out_in.neg   = neg_e_ff;
      out_in.degen = degen_e_ff;
      for (int k = 0; k < Lanes; k++) begin
         out_in.num[k] = NumBits'(plo_ff[k]) + (NumBits'(phi_ff[k]) << SplitBits)
                         + NumBits'(adet_e_ff);
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vd_ff <= 1'b0;
         ve_ff <= 1'b0;
         vf_ff <= 1'b0;
      end else begin
         vd_ff <= in_valid;
         ve_ff <= vd_ff;
         vf_ff <= ve_ff;
      end
   end

   assign out_valid = vf_ff;
   assign out_data  = out_ff;

endmodule

FILE: src/tls_div.sv
// ----------------------------------------------------------------------------
// tls_div
// pipelined restoring divider lane, one quotient bit per stage
// ----------------------------------------------------------------------------
module tls_div import tls_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  logic [NumBits-1:0]  in_num,
   input  logic [DenBits-1:0]  in_den,
   input  div_tag_type         in_tag,
   output logic                out_valid,
   output logic [QuotBits-1:0] out_quo,
   output logic                out_huge,
   output div_tag_type         out_tag
);

   logic [DenBits-1:0]  rem_ff  [QuotBits+1];
   logic [DenBits-1:0]  den_ff  [QuotBits+1];
   logic [QuotBits-1:0] low_ff  [QuotBits+1];
   logic [QuotBits-1:0] quo_ff  [QuotBits+1];
   logic                huge_ff [QuotBits+1];
   div_tag_type         tag_ff  [QuotBits+1];
   logic                vld_ff  [QuotBits+1];
   logic                huge_in;

   assign huge_in = DenBits'(in_num[NumBits-1:QuotBits]) >= in_den;

   always_ff @(posedge clock) begin
      rem_ff[0]  <= huge_in ? '0 : DenBits'(in_num[NumBits-1:QuotBits]);
      low_ff[0]  <= in_num[QuotBits-1:0];
      quo_ff[0]  <= '0;
      den_ff[0]  <= in_den;
      huge_ff[0] <= huge_in;
      tag_ff[0]  <= in_tag;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else begin
         vld_ff[0] <= in_valid;
      end
   end

   for (genvar s = 1; s <= QuotBits; s++) begin : g_step
      logic [DenBits:0] trial;
      logic             ge;

      assign trial = {rem_ff[s-1], low_ff[s-1][QuotBits-1]};
      assign ge    = trial >= {1'b0, den_ff[s-1]};

      always_ff @(posedge clock) begin
         rem_ff[s]  <= ge ? DenBits'(trial - {1'b0, den_ff[s-1]}) : trial[DenBits-1:0];
         low_ff[s]  <= low_ff[s-1] << 1;
         quo_ff[s]  <= {quo_ff[s-1][QuotBits-2:0], ge};
         den_ff[s]  <= den_ff[s-1];
         huge_ff[s] <= huge_ff[s-1];
         tag_ff[s]  <= tag_ff[s-1];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else begin
            vld_ff[s] <= vld_ff[s-1];
         end
      end
   end

   assign out_valid = vld_ff[QuotBits];
   assign out_quo   = quo_ff[QuotBits];
   assign out_huge  = huge_ff[QuotBits];
   assign out_tag   = tag_ff[QuotBits];

endmodule

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// checks the triangle stiffness unit against a wide-integer model of the six
// entries c*(bi*bj+gi*gj)/(2|det|) with rounding, clamping and the degenerate
// case; directed corner cases first, then random triangles of mixed scale,
// with random gaps on the request side and drain pauses
// ----------------------------------------------------------------------------
module tb import tls_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   typedef logic signed [255:0] wide_type;

   typedef struct {
      req_type data;
      bit      drain;
   } pend_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_valid;
   rsp_type rsp_data;

   pend_type pend_q[$];
   rsp_type  stiff_q[$];
   int       gap_left = 0;
   int       burst_left = 0;
   int       errors = 0;
   bit       stim_done = 1'b0;

   triangle_laplace_stiffness_unit u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data)
   );

   always #10 clock = ~clock;

   function automatic rsp_type stiffness_of(req_type r);
      wide_type x0, y0, x1, y1, x2, y2, det, adet, c, s, mag, q, lim;
      wide_type b[3], g[3];
      logic [OutBits-1:0] ent[Lanes];
      rsp_type res;
      int k;
      x0 = $signed(r.ax);
      y0 = $signed(r.ay);
      x1 = $signed(r.bx);
      y1 = $signed(r.by_coord);
      x2 = $signed(r.cx);
      y2 = $signed(r.cy);
      c = {225'b0, r.conductivity};
      lim = wide_type'(1) <<< (OutBits - 1);
      res = '0;
      det = (x1 - x0) * (y2 - y0) - (y1 - y0) * (x2 - x0);
      if (det == 0) begin
         res.degenerate = 1'b1;
         return res;
      end
      adet = det < 0 ? -det : det;
      b[0] = y1 - y2; b[1] = y2 - y0; b[2] = y0 - y1;
      g[0] = x2 - x1; g[1] = x0 - x2; g[2] = x1 - x0;
      k = 0;
      for (int i = 0; i < 3; i++) begin
         for (int j = i; j < 3; j++) begin
            s = b[i] * b[j] + g[i] * g[j];
            mag = s < 0 ? -s : s;
            q = (c * mag + adet) / (2 * adet);
            if (s < 0) begin
               if (q > lim) begin
                  q = lim;
                  res.saturated = 1'b1;
               end
               q = -q;
            end else if (q > lim - 1) begin
               q = lim - 1;
               res.saturated = 1'b1;
            end
            ent[k] = q[OutBits-1:0];
            k++;
         end
      end
      res.k_aa = ent[0]; res.k_ab = ent[1]; res.k_ac = ent[2];
      res.k_bb = ent[3]; res.k_bc = ent[4]; res.k_cc = ent[5];
      return res;
   endfunction

   function automatic int pick_gap();
      int p;
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      p = $urandom_range(99);
      if (p < 3) burst_left = $urandom_range(60, 10);
      if (p < 55) return 0;
      if (p < 92) return $urandom_range(3, 1);
      return $urandom_range(80, 10);
   endfunction

   // request driver
   always @(posedge clock) begin
      pend_type p;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) stiff_q.push_back(stiffness_of(req_data));
         if (!(start && busy)) begin
            if (gap_left > 0) begin
               gap_left--;
               start <= 1'b0;
            end else if (pend_q.size() > 0 && pend_q[0].drain && stiff_q.size() > 0) begin
               start <= 1'b0;
            end else if (pend_q.size() > 0) begin
               p = pend_q.pop_front();
               req_data <= p.data;
               start <= 1'b1;
               gap_left = pick_gap();
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   task automatic check_field(string name, logic [OutBits-1:0] want, logic [OutBits-1:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         errors++;
      end
   endtask

   // response monitor
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (stiff_q.size() == 0) begin
            $display("%0t: unexpected beat, expected none, actual %p", $time, rsp_data);
            errors++;
         end else begin
            want = stiff_q.pop_front();
            check_field("k_aa", want.k_aa, rsp_data.k_aa);
            check_field("k_ab", want.k_ab, rsp_data.k_ab);
            check_field("k_ac", want.k_ac, rsp_data.k_ac);
            check_field("k_bb", want.k_bb, rsp_data.k_bb);
            check_field("k_bc", want.k_bc, rsp_data.k_bc);
            check_field("k_cc", want.k_cc, rsp_data.k_cc);
            check_field("degenerate", want.degenerate, rsp_data.degenerate);
            check_field("saturated", want.saturated, rsp_data.saturated);
         end
      end
   end

   task automatic add_tri(int ax, int ay, int bx, int by, int cx, int cy,
                          logic [CondBits-1:0] c, bit drain = 1'b0);
      pend_type p;
      p.data = '{ax: ax, ay: ay, bx: bx, by_coord: by, cx: cx, cy: cy, conductivity: c};
      p.drain = drain;
      pend_q.push_back(p);
   endtask

   function automatic int rand_coord(int mode);
      case (mode)
         0: return int'($urandom());
         1: return $signed($urandom_range(65535)) - 32768;
         2: return $signed($urandom_range(32'h00FF_FFFF)) - 32'sh0080_0000;
         default: return $signed($urandom_range(1023)) - 512;
      endcase
   endfunction

   initial begin
      int mode, x0, y0, dx, dy;
      logic [CondBits-1:0] c;
      localparam int One = 32'h0001_0000;
      localparam int MaxC = 32'h7FFF_FFFF;
      localparam int MinC = 32'h8000_0000;
      localparam logic [CondBits-1:0] UnitC = 31'h0001_0000;
      // directed corners
      add_tri(0, 0, 0, 0, 0, 0, UnitC);
      add_tri(0, 0, One, 0, 0, One, UnitC);
      add_tri(0, 0, 0, One, One, 0, UnitC);
      add_tri(0, 0, One, One, 2 * One, 2 * One, UnitC);
      add_tri(0, 0, One, 0, 0, One, 31'h0);
      add_tri(0, 0, One, 0, 0, One, 31'h7FFF_FFFF);
      add_tri(0, 0, 1, 0, 0, 1, 31'h7FFF_FFFF);
      add_tri(0, 0, 1, 0, 0, 1, 31'h1);
      add_tri(MinC, MinC, MaxC, MinC, MinC, MaxC, 31'h7FFF_FFFF);
      add_tri(MaxC, MaxC, MinC, MaxC, MaxC, MinC, 31'h7FFF_FFFF);
      add_tri(MinC, 0, MaxC, 0, 0, MaxC, UnitC);
      add_tri(MinC, MinC, MaxC, MaxC, MinC, MaxC, 31'h1);
      add_tri(0, 0, MaxC, 1, 1, MaxC, 31'h7FFF_FFFF);
      add_tri(0, 0, MaxC, 0, MaxC, 1, 31'h7FFF_FFFF);
      add_tri(0, 0, MaxC, 0, MinC, 1, 31'h7FFF_FFFF, 1'b1);
      add_tri(-1, -1, -1, -1, -1, -1, 31'h7FFF_FFFF);
      add_tri(0, 0, 3, 0, 0, 2, 31'h1);
      add_tri(0, 0, 2, 0, 1, 2, 31'h3);
      add_tri(5 * One, -3 * One, -One, 7 * One, 2 * One, 2 * One, 31'h0003_8000);
      // random triangles, mixed scale, some degenerate and near degenerate
      for (int n = 0; n < 2000; n++) begin
         mode = $urandom_range(3);
         c = $urandom_range(9) == 0 ? 31'($urandom()) : 31'($urandom_range(32'h0010_0000));
         if ($urandom_range(19) == 0) c = 31'($urandom_range(1));
         x0 = rand_coord(mode);
         y0 = rand_coord(mode);
         case ($urandom_range(9))
            0: begin
               dx = rand_coord(3);
               dy = rand_coord(3);
               add_tri(x0, y0, x0 + dx, y0 + dy, x0 + 2 * dx, y0 + 2 * dy, c,
                       n % 400 == 399);
            end
            1: add_tri(x0, y0, x0 + 1, y0, x0 + rand_coord(3), y0 + 1, c, n % 400 == 399);
            default: add_tri(x0, y0, rand_coord(mode), rand_coord(mode),
                             rand_coord(mode), rand_coord(mode), c, n % 400 == 399);
         endcase
      end
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      while (pend_q.size() > 0 || start || stiff_q.size() > 0) @(posedge clock);
      repeat (Latency + 20) @(posedge clock);
      if (errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
